// ===== hw/rtl/atcd_pkg.sv =====
package atcd_pkg;

    // pixels in one 4x4 block and width of the pixel position
    localparam int unsigned PIXELS    = 16;
    localparam int unsigned PIX_IDX_W = 4;

    // interpolated alpha entries computed per block (ramp entries 2..7)
    localparam int unsigned RAMP_LANES = 6;

    // colour channels per palette entry
    localparam int unsigned CHANNELS = 3;

    // weighted alpha sum, at most 7*255+3
    localparam int unsigned SUM_W = 11;

    // reciprocal multiply for the divide by 7 and by 5 of the alpha sum
    localparam int unsigned RECIP_W     = 12;
    localparam int unsigned RECIP_SHIFT = 14;
    localparam int unsigned PROD_W      = SUM_W + RECIP_W;
    localparam logic [RECIP_W-1:0] RECIP7 = 12'd2341;
    localparam logic [RECIP_W-1:0] RECIP5 = 12'd3277;

    // alpha_mode register codes
    localparam logic ALPHA_EXPLICIT = 1'b0;
    localparam logic ALPHA_INTERP   = 1'b1;

    // everything the pixel stage needs for one block
    typedef struct packed {
        logic [3:0][23:0] palette;    // {b, g, r} per entry
        logic [7:0][7:0]  ramp;       // interpolated alpha values
        logic [31:0]      color_idx;  // 2-bit palette index per pixel
        logic [63:0]      alpha_bits; // explicit nibbles or a0, a1, 3-bit indices
    } blk_data_t;

    function automatic logic [7:0] expand5(input logic [4:0] v);
        expand5 = {v, v[4:2]};
    endfunction

    function automatic logic [7:0] expand6(input logic [5:0] v);
        expand6 = {v, v[5:4]};
    endfunction

endpackage

// ===== hw/rtl/atcd_color_lane.sv =====
module atcd_color_lane (
    input  logic            clk,
    input  logic            load,
    input  logic            black,
    input  logic [7:0]      lo,
    input  logic [7:0]      hi,
    output logic [3:0][7:0] pal
);

    logic [3:0][7:0] pal_reg;
    logic [3:0][7:0] pal_next;
    logic [10:0]     mix_lo;
    logic [10:0]     mix_hi;
    logic [7:0]      hi_quarter;
    logic [7:0]      floor_diff;

    // 5/8 and 3/8 blends
    assign mix_lo = 11'(hi) * 11'd3 + 11'(lo) * 11'd5;
    assign mix_hi = 11'(hi) * 11'd5 + 11'(lo) * 11'd3;

    // black mode: lo minus a quarter of hi, floored at zero
    assign hi_quarter = {2'b00, hi[7:2]};
    assign floor_diff = (lo > hi_quarter) ? (lo - hi_quarter) : 8'd0;

    always_comb
    begin
        if (black)
        begin
            pal_next[0] = 8'd0;
            pal_next[1] = floor_diff;
            pal_next[2] = lo;
            pal_next[3] = hi;
        end
        else
        begin
            pal_next[0] = lo;
            pal_next[1] = mix_lo[10:3];
            pal_next[2] = mix_hi[10:3];
            pal_next[3] = hi;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            pal_reg <= pal_next;
        end
    end

    assign pal = pal_reg;

endmodule

// ===== hw/rtl/atcd_alpha_lane.sv =====
module atcd_alpha_lane (
    input  logic       clk,
    input  logic       load_sum,
    input  logic       load_div,
    input  logic [2:0] lane_k,
    input  logic [7:0] a0,
    input  logic [7:0] a1,
    output logic [7:0] entry
);

    logic                            eight_next;
    logic [2:0]                      wa;
    logic [atcd_pkg::SUM_W-1:0]      rnd;
    logic [atcd_pkg::SUM_W-1:0]      sum_next;
    logic                            fixed_next;
    logic                            full_next;

    logic [atcd_pkg::SUM_W-1:0]      sum_reg;
    logic                            eight_reg;
    logic                            fixed_reg;
    logic                            full_reg;

    logic [atcd_pkg::RECIP_W-1:0]    recip;
    logic [atcd_pkg::PROD_W-1:0]     prod;
    logic [7:0]                      entry_next;
    logic [7:0]                      entry_reg;

    // weighted sum of the two endpoints, rounding term included
    assign eight_next = (a0 > a1);
    assign wa         = eight_next ? (3'd7 - lane_k) : (3'd5 - lane_k);
    assign rnd        = eight_next ? atcd_pkg::SUM_W'(3) : atcd_pkg::SUM_W'(2);
    assign sum_next   = atcd_pkg::SUM_W'(wa) * atcd_pkg::SUM_W'(a0)
                      + atcd_pkg::SUM_W'(lane_k) * atcd_pkg::SUM_W'(a1) + rnd;

    // six-value ramp: the top two entries are 0 and 255
    assign fixed_next = !eight_next && (lane_k > 3'd4);
    assign full_next  = (lane_k == 3'd6);

    always_ff @(posedge clk)
    begin
        if (load_sum)
        begin
            sum_reg   <= sum_next;
            eight_reg <= eight_next;
            fixed_reg <= fixed_next;
            full_reg  <= full_next;
        end
    end

    // divide by 7 or 5 through a reciprocal multiply
    assign recip = eight_reg ? atcd_pkg::RECIP7 : atcd_pkg::RECIP5;
    assign prod  = atcd_pkg::PROD_W'(sum_reg) * atcd_pkg::PROD_W'(recip);

    always_comb
    begin
        if (fixed_reg)
        begin
            entry_next = full_reg ? 8'hFF : 8'h00;
        end
        else
        begin
            entry_next = prod[atcd_pkg::RECIP_SHIFT +: 8];
        end
    end

    always_ff @(posedge clk)
    begin
        if (load_div)
        begin
            entry_reg <= entry_next;
        end
    end

    assign entry = entry_reg;

endmodule

// ===== hw/rtl/atcd_pixel_serializer.sv =====
module atcd_pixel_serializer (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              load,
    input  atcd_pkg::blk_data_t               data,
    input  logic                              alpha_mode,
    output logic                              free,
    output logic                              pix_valid,
    input  logic                              pix_stall,
    output logic [31:0]                       pixel_rgba,
    output logic [atcd_pkg::PIX_IDX_W-1:0]    pixel_index,
    output logic                              last_pixel
);

    logic                             valid_reg;
    logic                             valid_next;
    logic [atcd_pkg::PIX_IDX_W-1:0]   cnt_reg;
    logic [atcd_pkg::PIX_IDX_W-1:0]   cnt_next;

    logic [3:0][23:0]                 palette_reg;
    logic [7:0][7:0]                  ramp_reg;
    logic [31:0]                      cidx_reg;
    logic [63:0]                      anib_reg;
    logic [47:0]                      aidx_reg;

    logic                             beat;
    logic                             last;
    logic [7:0]                       alpha;

    assign beat = valid_reg && !pix_stall;
    assign last = (cnt_reg == atcd_pkg::PIX_IDX_W'(atcd_pkg::PIXELS - 1));
    assign free = !valid_reg || (beat && last);

    always_comb
    begin
        valid_next = valid_reg;
        cnt_next   = cnt_reg;
        if (load)
        begin
            valid_next = 1'b1;
            cnt_next   = '0;
        end
        else if (beat)
        begin
            valid_next = !last;
            cnt_next   = cnt_reg + 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            cnt_reg   <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
            cnt_reg   <= cnt_next;
        end
    end

    // per-pixel index fields shift down one pixel per beat
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            palette_reg <= data.palette;
            ramp_reg    <= data.ramp;
            cidx_reg    <= data.color_idx;
            anib_reg    <= data.alpha_bits;
            aidx_reg    <= data.alpha_bits[63:16];
        end
        else if (beat)
        begin
            cidx_reg <= {2'b00, cidx_reg[31:2]};
            anib_reg <= {4'h0, anib_reg[63:4]};
            aidx_reg <= {3'b000, aidx_reg[47:3]};
        end
    end

    always_comb
    begin
        unique case (alpha_mode)
            atcd_pkg::ALPHA_INTERP:   alpha = ramp_reg[aidx_reg[2:0]];
            atcd_pkg::ALPHA_EXPLICIT: alpha = {anib_reg[3:0], anib_reg[3:0]};
            default:                  alpha = {anib_reg[3:0], anib_reg[3:0]};
        endcase
    end

    assign pix_valid   = valid_reg;
    assign pixel_rgba  = {alpha, palette_reg[cidx_reg[1:0]]};
    assign pixel_index = cnt_reg;
    assign last_pixel  = last;

endmodule

// ===== hw/rtl/atc_texture_block_decoder.sv =====
// ATC RGBA 4x4 block decoder
// input channel (blk_valid / blk_stall): one beat is one compressed block,
//   alpha_block holds the alpha half, color_block the colour half
// output channel (pix_valid / pix_stall): sixteen beats per block, pixels in
//   raster order, pixel_index counts 0..15 and last_pixel marks the final one
// cfg_we / cfg_wdata write alpha_mode: 0 explicit 4-bit alpha, 1 ramp alpha;
//   write it only while no block is in flight
// latency: the first pixel of a block is offered three cycles after the edge
//   that takes its beat (input register loads on that edge, then palette and
//   alpha sum, alpha divide and the pixel stage)
// throughput: one block per 16 cycles, set by the pixel stage giving out one
//   pixel per cycle; later blocks wait in the pipeline registers meanwhile
// reset clears all valid flags and sets alpha_mode to explicit alpha
// while pix_stall is high the current pixel holds, the pipeline fills behind
//   it and blk_stall rises once every stage is occupied
module atc_texture_block_decoder (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_we,
    input  logic                            cfg_wdata,
    input  logic                            blk_valid,
    output logic                            blk_stall,
    input  logic [63:0]                     alpha_block,
    input  logic [63:0]                     color_block,
    output logic                            pix_valid,
    input  logic                            pix_stall,
    output logic [31:0]                     pixel_rgba,
    output logic [atcd_pkg::PIX_IDX_W-1:0]  pixel_index,
    output logic                            last_pixel
);

    // configuration
    logic alpha_mode_reg;

    // pipeline valid flags
    logic v1_reg, v1_next;
    logic v2_reg, v2_next;
    logic v3_reg, v3_next;
    logic rdy1, rdy2, rdy3;
    logic load1, load2, load3;
    logic ser_free;

    // stage payloads
    logic [63:0]      alpha_s1_reg;
    logic [63:0]      color_s1_reg;
    logic [63:0]      alpha_s2_reg;
    logic [31:0]      cidx_s2_reg;
    logic [63:0]      alpha_s3_reg;
    logic [31:0]      cidx_s3_reg;
    logic [3:0][23:0] pal_s3_reg;
    logic [3:0][23:0] pal_s3_next;

    // lane wiring
    logic [atcd_pkg::CHANNELS-1:0][7:0]        lo_chan;
    logic [atcd_pkg::CHANNELS-1:0][7:0]        hi_chan;
    logic [atcd_pkg::CHANNELS-1:0][3:0][7:0]   pal_chan;
    logic [atcd_pkg::RAMP_LANES-1:0][7:0]      ramp_mid;
    logic                                      black;

    atcd_pkg::blk_data_t blk_data;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            alpha_mode_reg <= atcd_pkg::ALPHA_EXPLICIT;
        end
        else if (cfg_we)
        begin
            alpha_mode_reg <= cfg_wdata;
        end
    end

    // each stage takes a new block when empty or when its block moves on
    assign rdy3 = !v3_reg || ser_free;
    assign rdy2 = !v2_reg || rdy3;
    assign rdy1 = !v1_reg || rdy2;

    assign load1 = rdy1 && blk_valid;
    assign load2 = rdy2 && v1_reg;
    assign load3 = rdy3 && v2_reg;

    assign v1_next = rdy1 ? blk_valid : v1_reg;
    assign v2_next = rdy2 ? v1_reg : v2_reg;
    assign v3_next = rdy3 ? v2_reg : v3_reg;

    assign blk_stall = !rdy1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= v1_next;
            v2_reg <= v2_next;
            v3_reg <= v3_next;
        end
    end

    // stage 1: input register
    always_ff @(posedge clk)
    begin
        if (load1)
        begin
            alpha_s1_reg <= alpha_block;
            color_s1_reg <= color_block;
        end
    end

    // endpoint expansion, channel 0 red, 1 green, 2 blue
    assign black      = color_s1_reg[15];
    assign lo_chan[0] = atcd_pkg::expand5(color_s1_reg[14:10]);
    assign lo_chan[1] = atcd_pkg::expand5(color_s1_reg[9:5]);
    assign lo_chan[2] = atcd_pkg::expand5(color_s1_reg[4:0]);
    assign hi_chan[0] = atcd_pkg::expand5(color_s1_reg[31:27]);
    assign hi_chan[1] = atcd_pkg::expand6(color_s1_reg[26:21]);
    assign hi_chan[2] = atcd_pkg::expand5(color_s1_reg[20:16]);

    // stage 2: one lane per colour channel builds its palette column
    for (genvar c = 0; c < atcd_pkg::CHANNELS; c++)
    begin : g_color
        atcd_color_lane u_color_lane (
            .clk   (clk),
            .load  (load2),
            .black (black),
            .lo    (lo_chan[c]),
            .hi    (hi_chan[c]),
            .pal   (pal_chan[c])
        );
    end

    // stages 2 and 3: one lane per interpolated alpha entry
    for (genvar k = 0; k < atcd_pkg::RAMP_LANES; k++)
    begin : g_alpha
        atcd_alpha_lane u_alpha_lane (
            .clk      (clk),
            .load_sum (load2),
            .load_div (load3),
            .lane_k   (3'(k + 1)),
            .a0       (alpha_s1_reg[7:0]),
            .a1       (alpha_s1_reg[15:8]),
            .entry    (ramp_mid[k])
        );
    end

    always_ff @(posedge clk)
    begin
        if (load2)
        begin
            alpha_s2_reg <= alpha_s1_reg;
            cidx_s2_reg  <= color_s1_reg[63:32];
        end
    end

    // merge the channel columns into {b, g, r} palette entries
    always_comb
    begin
        for (int e = 0; e < 4; e++)
        begin
            pal_s3_next[e] = {pal_chan[2][e], pal_chan[1][e], pal_chan[0][e]};
        end
    end

    // stage 3
    always_ff @(posedge clk)
    begin
        if (load3)
        begin
            alpha_s3_reg <= alpha_s2_reg;
            cidx_s3_reg  <= cidx_s2_reg;
            pal_s3_reg   <= pal_s3_next;
        end
    end

    // ramp entries 0 and 1 are the endpoints themselves
    assign blk_data.palette    = pal_s3_reg;
    assign blk_data.ramp       = {ramp_mid, alpha_s3_reg[15:8], alpha_s3_reg[7:0]};
    assign blk_data.color_idx  = cidx_s3_reg;
    assign blk_data.alpha_bits = alpha_s3_reg;

    // stage 4: pixel output, one pixel per beat
    atcd_pixel_serializer u_pixel_serializer (
        .clk         (clk),
        .rst_n       (rst_n),
        .load        (v3_reg && ser_free),
        .data        (blk_data),
        .alpha_mode  (alpha_mode_reg),
        .free        (ser_free),
        .pix_valid   (pix_valid),
        .pix_stall   (pix_stall),
        .pixel_rgba  (pixel_rgba),
        .pixel_index (pixel_index),
        .last_pixel  (last_pixel)
    );

endmodule
